### src/mcst_pkg.sv
// ----------------------------------------------------------------------------
// mcst_pkg
// Shared types and codes of the software timer bank: the request and fire
// transfer payloads, the per-slot record and the command and mode codes.
// ----------------------------------------------------------------------------
package mcst_pkg;

  localparam logic [2:0] CMD_TICK       = 3'd0;
  localparam logic [2:0] CMD_ATTACH     = 3'd1;
  localparam logic [2:0] CMD_START_ONCE = 3'd2;
  localparam logic [2:0] CMD_START_LOOP = 3'd3;
  localparam logic [2:0] CMD_RESTART    = 3'd4;
  localparam logic [2:0] CMD_DISABLE    = 3'd5;

  localparam logic [1:0] MODE_OFF  = 2'd0;
  localparam logic [1:0] MODE_ONCE = 2'd1;
  localparam logic [1:0] MODE_LOOP = 2'd2;

  typedef struct packed {
    logic [2:0]  command;
    logic [2:0]  slot;
    logic [31:0] period_ms;
    logic [31:0] now_ms;
  } mcst_req_t;

  typedef struct packed {
    logic [2:0] fired_slot;
    logic       last_fired;
  } mcst_fire_t;

  typedef struct packed {
    logic        attached;
    logic [1:0]  mode;
    logic [31:0] period;
    logic [31:0] start_time;
  } mcst_entry_t;

endpackage

### src/multi_channel_soft_timer.sv
// ----------------------------------------------------------------------------
// multi_channel_soft_timer
// Bank of one-shot / periodic software timer slots. Commands attach, start,
// restart or disable a slot; a tick scans all slots and reports each expiry.
// ----------------------------------------------------------------------------
//  channel | direction | payload      | handshake
//  req     | in        | mcst_req_t   | req_valid / req_stall
//  fire    | out       | mcst_fire_t  | fire_valid / fire_stall
//
//  A slot command is one memory read, then one write back.
//  A tick is accepted, then the scan reads one slot record per cycle from
//  the single-read-port memory unless a stalled fire holds it, then flushes.
//  A stalled fire output holds the scan only when a further expiry is found,
//  and holds the flush cycle while the last fire of the tick is pending.
//  Reset clears the slot valid bits at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
module multi_channel_soft_timer #(
  parameter int SLOTS = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_stall,
  input  mcst_pkg::mcst_req_t  req,
  output logic                 fire_valid,
  input  logic                 fire_stall,
  output mcst_pkg::mcst_fire_t fire
);
  import mcst_pkg::*;

  localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  logic [AW-1:0] rd_addr;
  mcst_entry_t   rd_data;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  mcst_entry_t   wr_data;

  mcst_mem #(
    .SLOTS (SLOTS),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .rst     (rst),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  mcst_ctrl #(
    .SLOTS (SLOTS),
    .AW    (AW)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .req        (req),
    .fire_valid (fire_valid),
    .fire_stall (fire_stall),
    .fire       (fire),
    .rd_addr    (rd_addr),
    .rd_data    (rd_data),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data)
  );

  a_tick_busy: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall && req.command == CMD_TICK |=> req_stall)
    else $error("tick transfer did not start a scan");

  a_mid_tick_busy: assert property (@(posedge clk) disable iff (rst)
    fire_valid && !fire.last_fired |-> req_stall)
    else $error("non-last fire shown while idle");

  a_fire_in_range: assert property (@(posedge clk) disable iff (rst)
    fire_valid |-> 7'(fire.fired_slot) < 7'(SLOTS))
    else $error("fired slot out of range");

  a_no_fire_on_cmd: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall && req.command != CMD_TICK && !fire_valid |=> !fire_valid)
    else $error("fire transfer caused by a slot command");

endmodule

### src/mcst_mem.sv
// ----------------------------------------------------------------------------
// mcst_mem
// Slot record memory: one write port, one read port with registered data.
// Per-entry valid bits make never-written entries read as the reset record.
// ----------------------------------------------------------------------------
module mcst_mem #(
  parameter int SLOTS = 8,
  parameter int AW    = 3
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [AW-1:0]         rd_addr,
  output mcst_pkg::mcst_entry_t rd_data,
  input  logic                  wr_en,
  input  logic [AW-1:0]         wr_addr,
  input  mcst_pkg::mcst_entry_t wr_data
);
  import mcst_pkg::*;

  mcst_entry_t      mem [SLOTS];
  logic [SLOTS-1:0] valid;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (wr_en) begin
      valid[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= valid[rd_addr] ? mem[rd_addr] : '0;
  end

endmodule

### src/mcst_ctrl.sv
// ----------------------------------------------------------------------------
// mcst_ctrl
// Command sequencer: read-modify-write of one slot per command, and a tick
// scan that checks one slot per cycle while no stalled fire holds it. A fired
// slot is held back one step so the last fire of a tick can be flagged.
// ----------------------------------------------------------------------------
module mcst_ctrl #(
  parameter int SLOTS = 8,
  parameter int AW    = 3
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  req_valid,
  output logic                  req_stall,
  input  mcst_pkg::mcst_req_t   req,
  output logic                  fire_valid,
  input  logic                  fire_stall,
  output mcst_pkg::mcst_fire_t  fire,
  output logic [AW-1:0]         rd_addr,
  input  mcst_pkg::mcst_entry_t rd_data,
  output logic                  wr_en,
  output logic [AW-1:0]         wr_addr,
  output mcst_pkg::mcst_entry_t wr_data
);
  import mcst_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_CMD, S_SCAN, S_FLUSH} state_t;

  localparam int LastIdx = SLOTS - 1;

  state_t      state;
  mcst_req_t   cur;
  logic [AW-1:0] idx;
  logic        pend_v;
  logic [AW-1:0] pend_slot;

  logic        accept;
  logic        slot_ok;
  logic        cmd_ok;
  logic        can_load;
  logic        is_last;
  logic        fire_hit;
  logic        hold;
  logic        fire_load;
  logic [31:0] elapsed;

  assign req_stall = (state != S_IDLE);
  assign accept    = req_valid && !req_stall;
  assign slot_ok   = 7'(req.slot) < 7'(SLOTS);
  assign cmd_ok    = (req.command >= CMD_ATTACH) && (req.command <= CMD_DISABLE);
  assign can_load  = !fire_valid || !fire_stall;
  assign is_last   = (idx == AW'(LastIdx));
  assign elapsed   = cur.now_ms - rd_data.start_time;
  assign fire_hit  = rd_data.attached && (rd_data.mode != MODE_OFF) &&
                     (elapsed > rd_data.period);
  assign hold      = fire_hit && pend_v && !can_load;
  assign fire_load = (state == S_SCAN && fire_hit && !hold && pend_v) ||
                     (state == S_FLUSH && pend_v && can_load);

  always_comb begin
    priority if (state == S_IDLE) begin
      rd_addr = (req.command == CMD_TICK) ? '0 : AW'(req.slot);
    end else if (state == S_SCAN && !hold && !is_last) begin
      rd_addr = idx + AW'(1);
    end else begin
      rd_addr = idx;
    end
  end

  always_comb begin
    wr_addr = idx;
    wr_data = rd_data;
    wr_en   = 1'b0;
    unique case (state)
      S_CMD: begin
        wr_en = 1'b1;
        unique case (cur.command)
          CMD_ATTACH: begin
            wr_data.attached   = 1'b1;
            wr_data.mode       = MODE_OFF;
            wr_data.period     = '0;
            wr_data.start_time = '0;
          end
          CMD_START_ONCE: begin
            wr_data.mode       = MODE_ONCE;
            wr_data.period     = cur.period_ms;
            wr_data.start_time = cur.now_ms;
          end
          CMD_START_LOOP: begin
            wr_data.mode       = MODE_LOOP;
            wr_data.period     = cur.period_ms;
            wr_data.start_time = cur.now_ms;
          end
          CMD_RESTART: begin
            if (rd_data.period != '0 && rd_data.mode != MODE_OFF) begin
              wr_data.start_time = cur.now_ms;
            end
          end
          CMD_DISABLE: begin
            wr_data.mode = MODE_OFF;
          end
          default: begin
            wr_en = 1'b0;
          end
        endcase
      end
      S_SCAN: begin
        wr_en              = fire_hit && !hold;
        wr_data.start_time = cur.now_ms;
        if (rd_data.mode == MODE_ONCE) begin
          wr_data.mode = MODE_OFF;
        end
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      pend_v     <= 1'b0;
      fire_valid <= 1'b0;
    end else begin
      if (fire_load) begin
        fire_valid <= 1'b1;
      end else if (fire_valid && !fire_stall) begin
        fire_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            cur <= req;
            if (req.command == CMD_TICK) begin
              idx   <= '0;
              state <= S_SCAN;
            end else if (cmd_ok && slot_ok) begin
              idx   <= AW'(req.slot);
              state <= S_CMD;
            end
          end
        end
        S_CMD: begin
          state <= S_IDLE;
        end
        S_SCAN: begin
          if (!hold) begin
            if (fire_hit) begin
              if (pend_v) begin
                fire.fired_slot <= 3'(pend_slot);
                fire.last_fired <= 1'b0;
              end
              pend_v    <= 1'b1;
              pend_slot <= idx;
            end
            if (is_last) begin
              state <= S_FLUSH;
            end else begin
              idx <= idx + AW'(1);
            end
          end
        end
        S_FLUSH: begin
          if (!pend_v) begin
            state <= S_IDLE;
          end else if (can_load) begin
            fire.fired_slot <= 3'(pend_slot);
            fire.last_fired <= 1'b1;
            pend_v          <= 1'b0;
            state           <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

### verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives multi_channel_soft_timer with commands and ticks over a valid/stall
// request channel, with random gaps on the request side and random stalls on
// the fire side. A directed table comes first, then random command streams.
// Fires are checked against a slot-bank model, or a typed row's own slot mask.
// ----------------------------------------------------------------------------
module testbench;
  import mcst_pkg::*;

  localparam int SLOTS        = 8;
  localparam int HALF_PERIOD  = 10;
  localparam int RESET_CYCLES = 6;
  localparam int RANDOM_ITEMS = 310;
  localparam int IDLE_LIMIT   = 4000;
  localparam int DRAIN_CYCLES = 4 * (SLOTS + 2);
  localparam int MAX_REPORTS  = 40;

  localparam logic [2:0] CMD_SPARE_6 = 3'd6;
  localparam logic [2:0] CMD_SPARE_7 = 3'd7;

  typedef struct {
    mcst_req_t        req;
    bit               typed;
    logic [SLOTS-1:0] fires;
  } plan_row_t;

  logic       clk        = 1'b0;
  logic       rst        = 1'b1;
  logic       req_valid  = 1'b0;
  logic       req_stall;
  mcst_req_t  req        = '0;
  logic       fire_valid;
  logic       fire_stall = 1'b0;
  mcst_fire_t fire;

  mcst_entry_t bank [SLOTS];
  mcst_fire_t  tick_fires [$];
  mcst_fire_t  fire_due [$];
  plan_row_t   plan [$];
  mcst_fire_t  want;

  int          errors     = 0;
  int          reqs_sent  = 0;
  int          fires_seen = 0;
  int          idle_count = 0;
  int          stall_left = 0;
  logic [31:0] clock_ms   = '0;

  multi_channel_soft_timer #(.SLOTS(SLOTS)) dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .fire_valid(fire_valid),
    .fire_stall(fire_stall),
    .fire      (fire)
  );

  always #(HALF_PERIOD) clk = ~clk;

  task automatic report_mismatch(input string what);
    errors++;
    if (errors <= MAX_REPORTS) begin
      $display("tb: mismatch at %0t: %s", $time, what);
    end
  endtask

  function automatic int idle_cycles(input bit quiet);
    if (quiet) return 0;
    return $urandom_range(0, 14);
  endfunction

  function automatic mcst_req_t mk_req(input logic [2:0] cmd, input logic [2:0] slot,
                                       input logic [31:0] per, input logic [31:0] now);
    mcst_req_t r;
    r.command   = cmd;
    r.slot      = slot;
    r.period_ms = per;
    r.now_ms    = now;
    return r;
  endfunction

  // Slot bank model: updates the bank and leaves this item's fires in tick_fires.
  task automatic advance_bank(input mcst_req_t r);
    logic [31:0] elapsed;
    tick_fires.delete();
    if (r.command == CMD_TICK) begin
      for (int i = 0; i < SLOTS; i++) begin
        elapsed = r.now_ms - bank[i].start_time;
        if (bank[i].attached && bank[i].mode != MODE_OFF && elapsed > bank[i].period) begin
          bank[i].start_time = r.now_ms;
          if (bank[i].mode == MODE_ONCE) bank[i].mode = MODE_OFF;
          tick_fires.push_back('{fired_slot: 3'(i), last_fired: 1'b0});
        end
      end
      if (tick_fires.size() > 0) tick_fires[tick_fires.size() - 1].last_fired = 1'b1;
    end else if (int'(r.slot) < SLOTS) begin
      case (r.command)
        CMD_ATTACH: begin
          bank[r.slot] = '{attached: 1'b1, mode: MODE_OFF, period: '0, start_time: '0};
        end
        CMD_START_ONCE: begin
          bank[r.slot].period     = r.period_ms;
          bank[r.slot].start_time = r.now_ms;
          bank[r.slot].mode       = MODE_ONCE;
        end
        CMD_START_LOOP: begin
          bank[r.slot].period     = r.period_ms;
          bank[r.slot].start_time = r.now_ms;
          bank[r.slot].mode       = MODE_LOOP;
        end
        CMD_RESTART: begin
          if (bank[r.slot].period != 0 && bank[r.slot].mode != MODE_OFF)
            bank[r.slot].start_time = r.now_ms;
        end
        CMD_DISABLE: begin
          bank[r.slot].mode = MODE_OFF;
        end
        default: ;
      endcase
    end
  endtask

  // One request transfer; typed rows carry their fires as a slot mask.
  task automatic issue_req(input mcst_req_t r, input bit typed, input logic [SLOTS-1:0] fires);
    int gap;
    int last;
    gap = idle_cycles((reqs_sent % 60) >= 45);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req       <= r;
    req_valid <= 1'b1;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    reqs_sent++;
    advance_bank(r);
    if (!typed) begin
      foreach (tick_fires[i]) fire_due.push_back(tick_fires[i]);
    end else begin
      last = -1;
      for (int i = 0; i < SLOTS; i++) if (fires[i]) last = i;
      for (int i = 0; i < SLOTS; i++) begin
        if (fires[i]) fire_due.push_back('{fired_slot: 3'(i), last_fired: (i == last)});
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst && fire_valid && !fire_stall) begin
      fires_seen++;
      if (fire_due.size() == 0) begin
        report_mismatch($sformatf("unexpected fire of slot %0d", fire.fired_slot));
      end else begin
        want = fire_due.pop_front();
        if (fire.fired_slot !== want.fired_slot)
          report_mismatch($sformatf("fired_slot %0d, want %0d", fire.fired_slot,
                                    want.fired_slot));
        if (fire.last_fired !== want.last_fired)
          report_mismatch($sformatf("last_fired %0b on slot %0d, want %0b", fire.last_fired,
                                    want.fired_slot, want.last_fired));
      end
      stall_left = idle_cycles((fires_seen % 50) >= 35);
    end
    if (stall_left > 0) begin
      fire_stall <= 1'b1;
      stall_left--;
    end else begin
      fire_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (fire_valid && !fire_stall)) begin
      idle_count <= 0;
    end else if (idle_count >= IDLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      idle_count <= idle_count + 1;
    end
  end

  initial begin
    int          counted;
    int          pick;
    logic [2:0]  s;
    logic [31:0] per;
    logic [31:0] now;
    mcst_req_t   r;

    foreach (bank[i]) bank[i] = '0;

    plan.push_back('{mk_req(CMD_TICK,       3'd0, 32'd0,         32'd0),         1'b1, 8'h00});
    plan.push_back('{mk_req(CMD_RESTART,    3'd0, 32'd7,         32'd5),         1'b0, 8'h00});
    plan.push_back('{mk_req(CMD_ATTACH,     3'd0, 32'd0,         32'd0),         1'b0, 8'h00});
    plan.push_back('{mk_req(CMD_ATTACH,     3'd7, 32'd0,         32'd0),         1'b0, 8'h00});
    plan.push_back('{mk_req(CMD_START_ONCE, 3'd0, 32'd0,         32'd100),       1'b0, 8'h00});
    plan.push_back('{mk_req(CMD_TICK,       3'd0, 32'd0,         32'd100),       1'b1, 8'h00});
    plan.push_back('{mk_req(CMD_TICK,       3'd0, 32'd0,         32'd101),       1'b1, 8'h01});
    plan.push_back('{mk_req(CMD_TICK,       3'd0, 32'd0,         32'd200),       1'b1, 8'h00});
    plan.push_back('{mk_req(CMD_START_LOOP, 3'd7, 32'hFFFF_FFFF, 32'd5),         1'b0, 8'h00});
    plan.push_back('{mk_req(CMD_TICK,       3'd0, 32'd0,         32'd4),         1'b1, 8'h00});
    plan.push_back('{mk_req(CMD_START_LOOP, 3'd7, 32'd10,        32'hFFFF_FFF8), 1'b0, 8'h00});
    plan.push_back('{mk_req(CMD_TICK,       3'd0, 32'd0,         32'd3),         1'b1, 8'h80});
    // start on a slot that is not attached: state taken, no fire
    plan.push_back('{mk_req(CMD_START_LOOP, 3'd3, 32'd0,         32'd0),         1'b0, 8'h00});
    plan.push_back('{mk_req(CMD_TICK,       3'd0, 32'd0,         32'd50),        1'b1, 8'h80});
    plan.push_back('{mk_req(CMD_ATTACH,     3'd3, 32'd0,         32'd0),         1'b0, 8'h00});
    plan.push_back('{mk_req(CMD_START_LOOP, 3'd3, 32'd0,         32'd50),        1'b0, 8'h00});
    plan.push_back('{mk_req(CMD_TICK,       3'd0, 32'd0,         32'd51),        1'b1, 8'h08});
    plan.push_back('{mk_req(CMD_RESTART,    3'd3, 32'd0,         32'd60),        1'b0, 8'h00});
    plan.push_back('{mk_req(CMD_TICK,       3'd0, 32'd0,         32'd70),        1'b1, 8'h88});
    plan.push_back('{mk_req(CMD_DISABLE,    3'd7, 32'd0,         32'd70),        1'b0, 8'h00});
    plan.push_back('{mk_req(CMD_RESTART,    3'd7, 32'd0,         32'd80),        1'b0, 8'h00});
    plan.push_back('{mk_req(CMD_SPARE_6,    3'd5, 32'hFFFF_FFFF, 32'hFFFF_FFFF), 1'b1, 8'h00});
    plan.push_back('{mk_req(CMD_SPARE_7,    3'd2, 32'h5555_AAAA, 32'hAAAA_5555), 1'b1, 8'h00});
    plan.push_back('{mk_req(CMD_START_ONCE, 3'd0, 32'h8000_0000, 32'd0),         1'b0, 8'h00});
    plan.push_back('{mk_req(CMD_TICK,       3'd0, 32'd0,         32'h8000_0001), 1'b1, 8'h09});

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) issue_req(plan[i].req, plan[i].typed, plan[i].fires);

    // every slot periodic with period 0, so one tick fires all of them
    clock_ms = 32'h8000_1000;
    for (int i = 0; i < SLOTS; i++) begin
      issue_req(mk_req(CMD_ATTACH, 3'(i), $urandom(), $urandom()), 1'b0, '0);
      issue_req(mk_req(CMD_START_LOOP, 3'(i), 32'd0, clock_ms), 1'b0, '0);
    end
    clock_ms = clock_ms + 32'd1;
    issue_req(mk_req(CMD_TICK, 3'($urandom_range(0, SLOTS - 1)), $urandom(), clock_ms), 1'b0, '0);
    counted = plan.size() + 2 * SLOTS + 1;

    while (counted < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      s    = 3'($urandom_range(0, SLOTS - 1));
      per  = $urandom();
      now  = ($urandom_range(0, 9) == 0) ? $urandom() : clock_ms;
      if (pick < 40) begin
        if ($urandom_range(0, 19) == 0) begin
          clock_ms = ($urandom_range(0, 1) == 1) ? $urandom()
                                                 : 32'hFFFF_FFF0 + 32'($urandom_range(0, 15));
        end else begin
          clock_ms = clock_ms + 32'($urandom_range(0, 25));
        end
        r = mk_req(CMD_TICK, s, per, clock_ms);
      end else if (pick < 50) begin
        r = mk_req(CMD_ATTACH, s, per, now);
      end else if (pick < 80) begin
        if ($urandom_range(0, 4) != 0) begin
          per = 32'($urandom_range(0, 40));
        end else begin
          case ($urandom_range(0, 2))
            0:       per = '0;
            1:       per = '1;
            default: ;
          endcase
        end
        r = mk_req((pick < 65) ? CMD_START_ONCE : CMD_START_LOOP, s, per, now);
      end else if (pick < 88) begin
        r = mk_req(CMD_RESTART, s, per, now);
      end else if (pick < 95) begin
        r = mk_req(CMD_DISABLE, s, per, now);
      end else begin
        r = mk_req(($urandom_range(0, 1) == 1) ? CMD_SPARE_7 : CMD_SPARE_6, s, per, $urandom());
      end
      issue_req(r, 1'b0, '0);
      counted++;
    end

    req_valid <= 1'b0;
    while (fire_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
